FILE: src/aging_address_cache_defines.svh
// Assertion macros for the aging address cache.
// Included by aging_address_cache, which carries concurrent assertions; no other dependencies.
`ifndef AGING_ADDRESS_CACHE_DEFINES_SVH
`define AGING_ADDRESS_CACHE_DEFINES_SVH

`ifndef ASSERT_OFF

// expression must hold at every edge outside reset
`define ACACHE_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("acache assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ACACHE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acache assertion failed");

// consequent must hold in the cycle after the antecedent
`define ACACHE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acache assertion failed");

`else

`define ACACHE_ASSERT(label, clk, rst, expr)
`define ACACHE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ACACHE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: src/acache_pkg.sv
// Shared constants, codes and interface structs for the aging address cache.
// No dependencies; used by acache_table and aging_address_cache.
package acache_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int ADDR_W        = 32;
   localparam int TIME_W        = 32;
   localparam int CNT_W         = 7;

   localparam logic [CNT_W-1:0]  COUNT_LIMIT   = 7'd127;
   localparam logic [TIME_W-1:0] RESET_MAX_AGE = 32'd3600;

   typedef logic [IDX_W-1:0] idx_type;

   localparam idx_type LAST_IDX = idx_type'(TABLE_ENTRIES - 1);

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_EXPIRE = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // controller -> table
   typedef struct packed {
      logic                rd_en;
      idx_type             rd_idx;
      logic                wr_en;
      idx_type             wr_idx;
      logic [ADDR_W-1:0]   wr_address;
      logic [TIME_W-1:0]   wr_time;
      logic                clr_en;
      idx_type             clr_idx;
      idx_type             probe_idx;
   } tbl_ctl_type;

   // table -> controller
   typedef struct packed {
      logic                rd_entry_valid;
      logic [ADDR_W-1:0]   rd_address;
      logic [TIME_W-1:0]   rd_time;
      logic                probe_valid;
   } tbl_stat_type;

endpackage

FILE: src/acache_table.sv
// Entry store: address/time memory with a registered read port, plus valid flops.
// Depends on acache_pkg.
module acache_table (
   input  logic                      clock,
   input  logic                      reset,
   input  acache_pkg::tbl_ctl_type   ctl,
   output acache_pkg::tbl_stat_type  stat
);

   logic [acache_pkg::ADDR_W+acache_pkg::TIME_W-1:0] entry_mem_ff [acache_pkg::TABLE_ENTRIES];
   logic [acache_pkg::ADDR_W+acache_pkg::TIME_W-1:0] rd_data_ff;
   logic                                             rd_valid_ff;
   logic [acache_pkg::TABLE_ENTRIES-1:0]             valid_ff;
   logic [acache_pkg::TABLE_ENTRIES-1:0]             valid_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         entry_mem_ff[ctl.wr_idx] <= {ctl.wr_address, ctl.wr_time};
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= entry_mem_ff[ctl.rd_idx];
         rd_valid_ff <= valid_ff[ctl.rd_idx];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_en) begin
         valid_in[ctl.wr_idx] = 1'b1;
      end
      if (ctl.clr_en) begin
         valid_in[ctl.clr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign stat.rd_entry_valid = rd_valid_ff;
   assign stat.rd_address     = rd_data_ff[acache_pkg::ADDR_W+acache_pkg::TIME_W-1:
                                           acache_pkg::TIME_W];
   assign stat.rd_time        = rd_data_ff[acache_pkg::TIME_W-1:0];
   assign stat.probe_valid    = valid_ff[ctl.probe_idx];

endmodule

FILE: src/aging_address_cache.sv
// Aging address cache: a table of IPv4 addresses stamped with their insert time.
// Request channel (req_*) takes an action, an address and the current time; each
// transaction yields one response transaction (rsp_*) with hit, accepted and
// removed_count, the fields not belonging to the action reading zero.
// csr_write_enable/csr_write_data load max_age; only write while the block is idle.
// Lookup and expire requests scan the TABLE_ENTRIES (N) slots of the entry memory,
// one slot per cycle on its single read port; an insert scans the valid flops in the same order:
//   lookup, expire : response after the scan of all N slots (lookup stops
//                    early on the first hit)
//   insert         : response once the lowest free slot takes the entry, or
//                    after the last slot when the table is full
//   action 3       : no operation, straight to the response
// One request at a time: req_stall is high from acceptance until the response
// is loaded into the output register, so the next request can be taken in the cycle
// after, while that response may still be waiting.
// A stalled response holds in the output register; a finished request waits until
// the register is empty or its response is taken before it is loaded.
// Reset empties the table at once (valid flops) and sets max_age to 3600.
// Depends on acache_pkg, acache_table and aging_address_cache_defines.svh.
`include "aging_address_cache_defines.svh"

module aging_address_cache (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_action,
   input  logic [acache_pkg::ADDR_W-1:0] req_ip_address,
   input  logic [acache_pkg::TIME_W-1:0] req_now,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_accepted,
   output logic [acache_pkg::CNT_W-1:0]  rsp_removed_count,
   input  logic                          csr_write_enable,
   input  logic [acache_pkg::TIME_W-1:0] csr_write_data
);

   acache_pkg::state_type            state_ff, state_in;
   acache_pkg::action_type           act_ff, act_in;
   logic [acache_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic [acache_pkg::TIME_W-1:0]    now_ff, now_in;
   logic [acache_pkg::TIME_W-1:0]    max_age_ff;
   acache_pkg::idx_type              scan_idx_ff, scan_idx_in;
   logic                             issue_on_ff, issue_on_in;
   logic                             rd_vld_ff, rd_vld_in;
   acache_pkg::idx_type              rd_idx_ff, rd_idx_in;
   logic                             res_hit_ff, res_hit_in;
   logic                             res_acc_ff, res_acc_in;
   logic [acache_pkg::CNT_W-1:0]     res_cnt_ff, res_cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_hit_ff, rsp_hit_in;
   logic                             rsp_accepted_ff, rsp_accepted_in;
   logic [acache_pkg::CNT_W-1:0]     rsp_count_ff, rsp_count_in;

   acache_pkg::tbl_ctl_type          tbl_ctl;
   acache_pkg::tbl_stat_type         tbl_stat;

   acache_table u_table (
      .clock (clock),
      .reset (reset),
      .ctl   (tbl_ctl),
      .stat  (tbl_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= acache_pkg::RESET_MAX_AGE;
      end else if (csr_write_enable) begin
         max_age_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acache_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         issue_on_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         issue_on_ff  <= issue_on_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff          <= act_in;
      addr_ff         <= addr_in;
      now_ff          <= now_in;
      scan_idx_ff     <= scan_idx_in;
      rd_idx_ff       <= rd_idx_in;
      res_hit_ff      <= res_hit_in;
      res_acc_ff      <= res_acc_in;
      res_cnt_ff      <= res_cnt_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_count_ff    <= rsp_count_in;
   end

   always_comb begin
      state_in        = state_ff;
      act_in          = act_ff;
      addr_in         = addr_ff;
      now_in          = now_ff;
      scan_idx_in     = scan_idx_ff;
      issue_on_in     = issue_on_ff;
      rd_vld_in       = 1'b0;
      rd_idx_in       = scan_idx_ff;
      res_hit_in      = res_hit_ff;
      res_acc_in      = res_acc_ff;
      res_cnt_in      = res_cnt_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_hit_in      = rsp_hit_ff;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_count_in    = rsp_count_ff;

      tbl_ctl            = '0;
      tbl_ctl.rd_idx     = scan_idx_ff;
      tbl_ctl.wr_idx     = scan_idx_ff;
      tbl_ctl.wr_address = addr_ff;
      tbl_ctl.wr_time    = now_ff;
      tbl_ctl.clr_idx    = rd_idx_ff;
      tbl_ctl.probe_idx  = scan_idx_ff;

      req_stall = (state_ff != acache_pkg::ST_IDLE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         acache_pkg::ST_IDLE: begin
            if (req_valid) begin
               act_in      = acache_pkg::action_type'(req_action);
               addr_in     = req_ip_address;
               now_in      = req_now;
               scan_idx_in = '0;
               issue_on_in = 1'b1;
               res_hit_in  = 1'b0;
               res_acc_in  = 1'b0;
               res_cnt_in  = '0;
               if (acache_pkg::action_type'(req_action) == acache_pkg::ACT_NOP) begin
                  state_in = acache_pkg::ST_FINISH;
               end else begin
                  state_in = acache_pkg::ST_SCAN;
               end
            end
         end
         acache_pkg::ST_SCAN: begin
            if (act_ff == acache_pkg::ACT_INSERT) begin
               // first free slot in index order takes the entry
               if (!tbl_stat.probe_valid) begin
                  tbl_ctl.wr_en = 1'b1;
                  res_acc_in    = 1'b1;
                  state_in      = acache_pkg::ST_FINISH;
               end else if (scan_idx_ff == acache_pkg::LAST_IDX) begin
                  state_in = acache_pkg::ST_FINISH;
               end else begin
                  scan_idx_in = scan_idx_ff + acache_pkg::idx_type'(1);
               end
            end else begin
               // issue one read a cycle; evaluate the slot read last cycle
               if (issue_on_ff) begin
                  tbl_ctl.rd_en = 1'b1;
                  rd_vld_in     = 1'b1;
                  if (scan_idx_ff == acache_pkg::LAST_IDX) begin
                     issue_on_in = 1'b0;
                  end else begin
                     scan_idx_in = scan_idx_ff + acache_pkg::idx_type'(1);
                  end
               end
               if (rd_vld_ff) begin
                  if (act_ff == acache_pkg::ACT_LOOKUP) begin
                     if (tbl_stat.rd_entry_valid && tbl_stat.rd_address == addr_ff &&
                         addr_ff != '0) begin
                        res_hit_in = 1'b1;
                        state_in   = acache_pkg::ST_FINISH;
                     end
                  end else if (tbl_stat.rd_entry_valid &&
                               (now_ff - tbl_stat.rd_time) > max_age_ff) begin
                     tbl_ctl.clr_en = 1'b1;
                     if (res_cnt_ff != acache_pkg::COUNT_LIMIT) begin
                        res_cnt_in = res_cnt_ff + acache_pkg::CNT_W'(1);
                     end
                  end
                  if (rd_idx_ff == acache_pkg::LAST_IDX) begin
                     state_in = acache_pkg::ST_FINISH;
                  end
               end
            end
         end
         acache_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = res_hit_ff;
               rsp_accepted_in = res_acc_ff;
               rsp_count_in    = res_cnt_ff;
               state_in        = acache_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = acache_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_removed_count = rsp_count_ff;

   // at most one result field is set per response
   `ACACHE_ASSERT_IMPLY(a_one_result, clock, reset, rsp_valid_ff,
      $countones({rsp_hit_ff, rsp_accepted_ff, |rsp_count_ff}) <= 1)
   // memory is only written by an insert scan
   `ACACHE_ASSERT_IMPLY(a_write_insert, clock, reset, tbl_ctl.wr_en,
      state_ff == acache_pkg::ST_SCAN && act_ff == acache_pkg::ACT_INSERT)
   // entries are only cleared by an expire scan
   `ACACHE_ASSERT_IMPLY(a_clear_expire, clock, reset, tbl_ctl.clr_en,
      state_ff == acache_pkg::ST_SCAN && act_ff == acache_pkg::ACT_EXPIRE && rd_vld_ff)
   // removed count never exceeds the table size
   `ACACHE_ASSERT_IMPLY(a_count_bound, clock, reset, rsp_valid_ff,
      32'(rsp_count_ff) <= 32'(acache_pkg::TABLE_ENTRIES))
   // an accepted transaction always leaves idle
   `ACACHE_ASSERT_NEXT(a_leave_idle, clock, reset, req_valid && !req_stall,
      state_ff == acache_pkg::ST_SCAN || state_ff == acache_pkg::ST_FINISH)

endmodule

FILE: tb/sv/aging_address_cache_tb.sv
// Self-checking testbench for aging_address_cache: directed and random request
// traffic against an in-bench model of the address table. Depends on acache_pkg and aging_address_cache.
`timescale 1ns / 1ps

module aging_address_cache_tb;

   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      logic                         hit;
      logic                         accepted;
      logic [acache_pkg::CNT_W-1:0] removed_count;
   } cache_response_type;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_action       = acache_pkg::ACT_NOP;
   logic [acache_pkg::ADDR_W-1:0] req_ip_address   = '0;
   logic [acache_pkg::TIME_W-1:0] req_now          = '0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   logic                          rsp_hit;
   logic                          rsp_accepted;
   logic [acache_pkg::CNT_W-1:0]  rsp_removed_count;
   logic                          csr_write_enable = 1'b0;
   logic [acache_pkg::TIME_W-1:0] csr_write_data   = '0;

   // model of the table and its register
   logic                          slot_used  [acache_pkg::TABLE_ENTRIES] = '{default: 1'b0};
   logic [acache_pkg::ADDR_W-1:0] slot_addr  [acache_pkg::TABLE_ENTRIES];
   logic [acache_pkg::TIME_W-1:0] slot_stamp [acache_pkg::TABLE_ENTRIES];
   logic [acache_pkg::TIME_W-1:0] max_age_model = acache_pkg::RESET_MAX_AGE;

   cache_response_type            pending_responses [$];
   logic [acache_pkg::TIME_W-1:0] wall_time = '0;
   bit                            idle_enable = 1'b1;
   int                            mismatch_count = 0;
   int                            cycle_count = 0;
   int                            request_count = 0;
   int                            hit_count = 0;
   int                            reject_count = 0;
   int                            aged_out_count = 0;
   int                            max_age_writes = 0;

   aging_address_cache i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_ip_address    (req_ip_address),
      .req_now           (req_now),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_accepted      (rsp_accepted),
      .rsp_removed_count (rsp_removed_count),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  pending_responses.size());
         $display("FAIL");
         $finish;
      end
   end

   function automatic cache_response_type predict_cache_response(
         acache_pkg::action_type op, logic [acache_pkg::ADDR_W-1:0] addr,
         logic [acache_pkg::TIME_W-1:0] stamp);
      cache_response_type            r;
      logic [acache_pkg::TIME_W-1:0] age;
      r = '0;
      request_count++;
      case (op)
         acache_pkg::ACT_LOOKUP: begin
            if (addr != '0)
               for (int i = 0; i < acache_pkg::TABLE_ENTRIES; i++)
                  if (slot_used[i] && slot_addr[i] == addr)
                     r.hit = 1'b1;
            if (r.hit)
               hit_count++;
         end
         acache_pkg::ACT_INSERT: begin
            // lowest free slot wins, duplicates are not checked
            for (int i = 0; i < acache_pkg::TABLE_ENTRIES; i++)
               if (!slot_used[i] && !r.accepted) begin
                  slot_used[i]  = 1'b1;
                  slot_addr[i]  = addr;
                  slot_stamp[i] = stamp;
                  r.accepted    = 1'b1;
               end
            if (!r.accepted)
               reject_count++;
         end
         acache_pkg::ACT_EXPIRE: begin
            for (int i = 0; i < acache_pkg::TABLE_ENTRIES; i++) begin
               age = stamp - slot_stamp[i];
               if (slot_used[i] && age > max_age_model) begin
                  slot_used[i] = 1'b0;
                  if (r.removed_count < acache_pkg::COUNT_LIMIT)
                     r.removed_count++;
               end
            end
            aged_out_count += r.removed_count;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_request(acache_pkg::action_type op,
         logic [acache_pkg::ADDR_W-1:0] addr, logic [acache_pkg::TIME_W-1:0] stamp);
      int gap;
      gap = idle_enable ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= op;
      req_ip_address <= addr;
      req_now        <= stamp;
      do @(posedge clock); while (req_stall);
      pending_responses.push_back(predict_cache_response(op, addr, stamp));
   endtask

   // hold off the sender until every outstanding transaction has completed
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_max_age(logic [acache_pkg::TIME_W-1:0] value);
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      max_age_model = value;
      max_age_writes++;
   endtask

   // receiver: random stall ahead of each response while idle_enable is set
   initial begin
      int hold;
      forever begin
         hold = idle_enable ? $urandom_range(0, 3) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   always @(posedge clock) begin
      cache_response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            $display("%0t: response with none expected, actual hit %0d accepted %0d removed %0d",
                     $time, rsp_hit, rsp_accepted, rsp_removed_count);
            mismatch_count++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit mismatch, expected %0d, actual %0d",
                        $time, want.hit, rsp_hit);
               mismatch_count++;
            end
            if (rsp_accepted !== want.accepted) begin
               $display("%0t: accepted mismatch, expected %0d, actual %0d",
                        $time, want.accepted, rsp_accepted);
               mismatch_count++;
            end
            if (rsp_removed_count !== want.removed_count) begin
               $display("%0t: removed_count mismatch, expected %0d, actual %0d",
                        $time, want.removed_count, rsp_removed_count);
               mismatch_count++;
            end
         end
      end
   end

   // address zero, duplicates, the age boundary, time wrap, the unused code
   task automatic test_special_cases();
      send_request(acache_pkg::ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_request(acache_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(acache_pkg::ACT_EXPIRE, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(acache_pkg::ACT_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(acache_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(acache_pkg::ACT_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_request(acache_pkg::ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_request(acache_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(acache_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0005);
      send_request(acache_pkg::ACT_LOOKUP, 32'h0000_0001, 32'h0000_0000);
      send_request(acache_pkg::ACT_EXPIRE, 32'h0000_0000, 32'd3600);
      send_request(acache_pkg::ACT_EXPIRE, 32'h0000_0000, 32'd3601);
      send_request(acache_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'd3601);
      send_request(acache_pkg::ACT_EXPIRE, 32'h0000_0000, 32'd3605);
      send_request(acache_pkg::ACT_EXPIRE, 32'h0000_0000, 32'd3606);
      send_request(acache_pkg::ACT_INSERT, 32'h1234_5678, 32'hFFFF_FFF0);
      send_request(acache_pkg::ACT_EXPIRE, 32'h0000_0000, 32'h0000_0010);
      send_request(acache_pkg::ACT_LOOKUP, 32'h1234_5678, 32'h0000_0010);
      send_request(acache_pkg::ACT_NOP,    32'h0000_0000, 32'h0000_0000);
   endtask

   task automatic test_max_age_extremes();
      write_max_age(32'h0000_0000);
      send_request(acache_pkg::ACT_INSERT, 32'hC0A8_0001, 32'd1000);
      send_request(acache_pkg::ACT_EXPIRE, 32'h0000_0000, 32'd1000);
      send_request(acache_pkg::ACT_LOOKUP, 32'hC0A8_0001, 32'd1000);
      send_request(acache_pkg::ACT_EXPIRE, 32'h0000_0000, 32'd1001);
      send_request(acache_pkg::ACT_LOOKUP, 32'hC0A8_0001, 32'd1001);
      write_max_age(32'hFFFF_FFFF);
      send_request(acache_pkg::ACT_INSERT, 32'h0A00_0001, 32'h0000_0000);
      send_request(acache_pkg::ACT_EXPIRE, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(acache_pkg::ACT_LOOKUP, 32'h0A00_0001, 32'hFFFF_FFFF);
   endtask

   task automatic test_table_full();
      logic [acache_pkg::ADDR_W-1:0] first_addr;
      first_addr = $urandom;
      send_request(acache_pkg::ACT_INSERT, first_addr, wall_time);
      repeat (acache_pkg::TABLE_ENTRIES + 2)
         send_request(acache_pkg::ACT_INSERT, $urandom, wall_time + $urandom_range(0, 9));
      send_request(acache_pkg::ACT_LOOKUP, first_addr, wall_time);
      send_request(acache_pkg::ACT_LOOKUP, $urandom, wall_time);
      write_max_age(32'h0000_0000);
      send_request(acache_pkg::ACT_EXPIRE, $urandom, wall_time + 32'd10);
      send_request(acache_pkg::ACT_LOOKUP, first_addr, wall_time);
   endtask

   task automatic test_random_traffic();
      logic [acache_pkg::ADDR_W-1:0] addr_pool [16];
      logic [acache_pkg::ADDR_W-1:0] addr;
      int                            sel;
      foreach (addr_pool[i])
         addr_pool[i] = $urandom;
      addr_pool[0] = '0;
      wall_time = 32'd100;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0:       write_max_age(acache_pkg::RESET_MAX_AGE);
            4:       write_max_age($urandom);
            default: write_max_age($urandom_range(16, 1500));
         endcase
         idle_enable = (phase % 4 != 3);
         repeat (190) begin
            sel = $urandom_range(0, 99);
            wall_time += $urandom_range(0, 12);
            if (sel < 3)
               wall_time = $urandom;
            addr = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 15)];
            if (sel < 40)
               send_request(acache_pkg::ACT_LOOKUP, addr, wall_time);
            else if (sel < 75)
               send_request(acache_pkg::ACT_INSERT, addr, wall_time);
            else if (sel < 92)
               send_request(acache_pkg::ACT_EXPIRE, $urandom, wall_time);
            else if (sel < 96)
               send_request(acache_pkg::ACT_NOP, addr, wall_time);
            else
               send_request(acache_pkg::action_type'($urandom_range(0, 3)),
                            $urandom, $urandom);
         end
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_special_cases();
      test_max_age_extremes();
      test_table_full();
      test_random_traffic();
      wait_until_drained();
      repeat (acache_pkg::TABLE_ENTRIES + 8) @(posedge clock);
      if (pending_responses.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_responses.size());
         mismatch_count++;
      end
      $display("Covered %0d requests: %0d lookup hits, %0d inserts refused on a full table,",
               request_count, hit_count, reject_count);
      $display("%0d entries aged out across %0d max_age settings", aged_out_count,
               max_age_writes);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
